// File: sv/radix_partition_write_combiner_core_assert.svh
// Assertion macros used by the write combiner core RTL.
`ifndef RADIX_PARTITION_WRITE_COMBINER_CORE_ASSERT_SVH
`define RADIX_PARTITION_WRITE_COMBINER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RPWC_ASSERT(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
`define RPWC_ASSERT_NEXT(lbl, clk_s, rst_s, pre, post, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) pre |=> post) else $error(msg);
`else
`define RPWC_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define RPWC_ASSERT_NEXT(lbl, clk_s, rst_s, pre, post, msg)
`endif
`endif

// File: sv/rpwc_pkg.sv
// Types and constants of the radix partition write combiner.
package rpwc_pkg;
    localparam int PARTITIONS_DEF = 256;
    localparam int LINE_SIZE_DEF  = 64;
    localparam int ADDR_BITS_DEF  = 48;
    localparam int OUT_ADDR_W     = 48;
    localparam int COUNT_W        = 7;
    localparam int ELEM_BYTES     = 32;
    localparam int OUT_BYTES      = 64;
    localparam int IN_DATA_W      = 344;
    localparam int OUT_DATA_W     = 568;

    typedef enum logic [1:0] {
        MODE_SEED  = 2'd0,
        MODE_ROW   = 2'd1,
        MODE_DRAIN = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        KIND_PEEL  = 2'd0,
        KIND_LINE  = 2'd1,
        KIND_RESID = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CFG_SHIFT = 2'd0,
        CFG_MASK  = 2'd1,
        CFG_WIDTH = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic  meta_we;
        logic  line_we;
        logic  emit;
        kind_t kind;
    } upd_ctl_t;
endpackage

// File: sv/rpwc_ram.sv
// Generic single-port-write, registered-read RAM.
module rpwc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// File: sv/rpwc_update.sv
// Per-request update of one partition: seed, head peel, line staging, line and drain emission.
module rpwc_update import rpwc_pkg::*; #(
    parameter int LINE_SIZE = LINE_SIZE_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF,
    localparam int FB = $clog2(LINE_SIZE),
    localparam int LB = LINE_SIZE * 8
) (
    input  mode_t                    mode,
    input  logic [1:0]               width_code,
    input  logic [ADDR_BITS-1:0]     base_address,
    input  logic [ADDR_BITS-1:0]     cursor,
    input  logic [FB-1:0]            fill,
    input  logic [LB-1:0]            line,
    input  logic [ELEM_BYTES*8-1:0]  elem,
    output upd_ctl_t                 ctl,
    output logic [ADDR_BITS-1:0]     new_cursor,
    output logic [FB-1:0]            new_fill,
    output logic [LB-1:0]            new_line,
    output logic [COUNT_W-1:0]       count,
    output logic [OUT_BYTES*8-1:0]   words
);
    logic [COUNT_W-1:0]     width_b;
    logic                   aligned;
    logic [LB-1:0]          elem_ext;
    logic [LB-1:0]          shifted;
    logic [LB-1:0]          merged;
    logic [FB:0]            sum;
    logic                   full;
    logic [LB-1:0]          src;
    logic [OUT_BYTES*8-1:0] src_ext;

    assign width_b  = COUNT_W'(7'd4 << width_code);
    assign aligned  = (cursor[FB-1:0] == '0);
    assign elem_ext = LB'(elem);
    assign shifted  = elem_ext << {fill, 3'b000};
    assign sum      = (FB+1)'(fill) + (FB+1)'(width_b);
    assign full     = (sum >= (FB+1)'(LINE_SIZE));

    // element bytes land at fill .. fill+width-1; bytes past the line are dropped
    always_comb
    begin
        for (int j = 0; j < LINE_SIZE; j++)
        begin
            if (j >= int'(fill) && j < int'(sum))
                merged[j*8 +: 8] = shifted[j*8 +: 8];
            else
                merged[j*8 +: 8] = line[j*8 +: 8];
        end
    end

    always_comb
    begin
        ctl        = '{meta_we: 1'b0, line_we: 1'b0, emit: 1'b0, kind: KIND_PEEL};
        new_cursor = cursor;
        new_fill   = fill;
        new_line   = merged;
        count      = '0;
        src        = line;
        unique case (mode)
            MODE_SEED:
            begin
                ctl.meta_we = 1'b1;
                new_cursor  = base_address;
                new_fill    = '0;
            end
            MODE_ROW:
            begin
                ctl.meta_we = 1'b1;
                if (!aligned)
                begin
                    ctl.emit   = 1'b1;
                    ctl.kind   = KIND_PEEL;
                    count      = width_b;
                    src        = elem_ext;
                    new_cursor = cursor + ADDR_BITS'(width_b);
                end
                else
                begin
                    ctl.line_we = 1'b1;
                    if (full)
                    begin
                        ctl.emit   = 1'b1;
                        ctl.kind   = KIND_LINE;
                        count      = COUNT_W'(LINE_SIZE);
                        src        = merged;
                        new_cursor = cursor + ADDR_BITS'(LINE_SIZE);
                        new_fill   = '0;
                    end
                    else
                    begin
                        new_fill = sum[FB-1:0];
                    end
                end
            end
            MODE_DRAIN:
            begin
                if (fill != '0)
                begin
                    ctl.meta_we = 1'b1;
                    ctl.emit    = 1'b1;
                    ctl.kind    = KIND_RESID;
                    count       = COUNT_W'(fill);
                    new_cursor  = cursor + ADDR_BITS'(fill);
                    new_fill    = '0;
                end
            end
            default:
            begin
                ctl.meta_we = 1'b0;
            end
        endcase
    end

    assign src_ext = (OUT_BYTES*8)'(src);

    always_comb
    begin
        for (int j = 0; j < OUT_BYTES; j++)
        begin
            words[j*8 +: 8] = (j < int'(count)) ? src_ext[j*8 +: 8] : 8'h00;
        end
    end
endmodule

// File: sv/radix_partition_write_combiner_core.sv
// Radix partition write combiner: one request per cycle in a two-stage pipeline. A
// request is routed and its partition entry read from the cursor/fill RAM and the line
// RAM in the first stage; the second stage merges, decides on a result and writes the
// entry back, forwarding a write-back to the following request when it hits the same
// partition. Sustained rate is one request per clock, set by that single read-modify-
// write per partition. A result is registered as its request leaves the second stage
// and waits in an output register; while it is not taken, the second stage holds, one
// more request is accepted into it and then the input stalls. Fill counts come out of
// reset zero through per-partition valid bits, so no clearing pass runs after reset.
`include "radix_partition_write_combiner_core_assert.svh"
module radix_partition_write_combiner_core import rpwc_pkg::*; #(
    parameter int PARTITIONS = PARTITIONS_DEF,
    parameter int LINE_SIZE  = LINE_SIZE_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // row_hash, target_partition, base_address, in_word0..in_word3
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // mode
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // write_address, byte_count, line_word0..line_word7, one zero pad bit
    output logic [OUT_DATA_W-1:0] m_tdata,
    // write_kind
    output logic [1:0]            m_tuser
);
    localparam int PB = $clog2(PARTITIONS);
    localparam int FB = $clog2(LINE_SIZE);
    localparam int LB = LINE_SIZE * 8;
    localparam int MW = ADDR_BITS + FB;

    logic [4:0] shift_reg;
    logic [7:0] mask_reg;
    logic [1:0] wcode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 5'd0;
            mask_reg  <= 8'd255;
            wcode_reg <= 2'd1;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_SHIFT)
                shift_reg <= cfg_data[4:0];
            else if (cfg_index == CFG_MASK)
                mask_reg <= cfg_data;
            else if (cfg_index == CFG_WIDTH)
                wcode_reg <= cfg_data[1:0];
        end
    end

    // stage 0: route
    logic          in_fire;
    mode_t         in_mode;
    logic [31:0]   route;
    logic [PB-1:0] in_part;

    assign in_fire = s_tvalid && s_tready;
    assign in_mode = mode_t'(s_tuser);
    assign route   = (s_tdata[31:0] >> shift_reg) & {24'd0, mask_reg};
    assign in_part = (in_mode == MODE_ROW) ? route[PB-1:0] : PB'(s_tdata[39:32]);

    // stage 1 registers
    logic                   s1_valid_reg;
    mode_t                  s1_mode_reg;
    logic [PB-1:0]          s1_part_reg;
    logic [ADDR_BITS-1:0]   s1_base_reg;
    logic [ELEM_BYTES*8-1:0] s1_elem_reg;
    logic                   s1_fwd_meta_reg;
    logic                   s1_fwd_line_reg;
    logic                   s1_vld_reg;
    logic [MW-1:0]          fwd_meta_reg;
    logic [LB-1:0]          fwd_line_reg;
    logic [PARTITIONS-1:0]  vld_reg;
    logic                   out_valid_reg;
    kind_t                  out_kind_reg;
    logic [OUT_ADDR_W-1:0]  out_addr_reg;
    logic [COUNT_W-1:0]     out_count_reg;
    logic [OUT_BYTES*8-1:0] out_words_reg;

    logic                   s1_go;
    logic                   meta_we;
    logic                   line_we;
    logic [MW-1:0]          meta_rdata;
    logic [LB-1:0]          line_rdata;
    logic [MW-1:0]          meta_cur;
    logic [LB-1:0]          line_cur;
    upd_ctl_t               ctl;
    logic [ADDR_BITS-1:0]   new_cursor;
    logic [FB-1:0]          new_fill;
    logic [LB-1:0]          new_line;
    logic [COUNT_W-1:0]     upd_count;
    logic [OUT_BYTES*8-1:0] upd_words;

    assign s1_go    = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_go;
    assign meta_we  = s1_go && ctl.meta_we;
    assign line_we  = s1_go && ctl.line_we;

    rpwc_ram #(.WIDTH(MW), .DEPTH(PARTITIONS)) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (s1_part_reg),
        .wdata ({new_cursor, new_fill}),
        .re    (in_fire),
        .raddr (in_part),
        .rdata (meta_rdata)
    );

    rpwc_ram #(.WIDTH(LB), .DEPTH(PARTITIONS)) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (s1_part_reg),
        .wdata (new_line),
        .re    (in_fire),
        .raddr (in_part),
        .rdata (line_rdata)
    );

    // never-written entries read as cursor zero, fill zero
    assign meta_cur = s1_fwd_meta_reg ? fwd_meta_reg : (s1_vld_reg ? meta_rdata : '0);
    assign line_cur = s1_fwd_line_reg ? fwd_line_reg : line_rdata;

    rpwc_update #(.LINE_SIZE(LINE_SIZE), .ADDR_BITS(ADDR_BITS)) u_update (
        .mode         (s1_mode_reg),
        .width_code   (wcode_reg),
        .base_address (s1_base_reg),
        .cursor       (meta_cur[MW-1:FB]),
        .fill         (meta_cur[FB-1:0]),
        .line         (line_cur),
        .elem         (s1_elem_reg),
        .ctl          (ctl),
        .new_cursor   (new_cursor),
        .new_fill     (new_fill),
        .new_line     (new_line),
        .count        (upd_count),
        .words        (upd_words)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s1_fwd_meta_reg <= 1'b0;
            s1_fwd_line_reg <= 1'b0;
            s1_vld_reg      <= 1'b0;
            vld_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg    <= 1'b1;
                // a write-back at this edge is not yet seen by the RAM read
                s1_fwd_meta_reg <= meta_we && (s1_part_reg == in_part);
                s1_fwd_line_reg <= line_we && (s1_part_reg == in_part);
                s1_vld_reg      <= vld_reg[in_part];
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (meta_we)
            begin
                vld_reg[s1_part_reg] <= 1'b1;
            end
            if (s1_go && ctl.emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_mode_reg <= in_mode;
            s1_part_reg <= in_part;
            s1_base_reg <= ADDR_BITS'(s_tdata[87:40]);
            s1_elem_reg <= s_tdata[343:88];
        end
        if (meta_we)
            fwd_meta_reg <= {new_cursor, new_fill};
        if (line_we)
            fwd_line_reg <= new_line;
        if (s1_go && ctl.emit)
        begin
            out_kind_reg  <= ctl.kind;
            out_addr_reg  <= OUT_ADDR_W'(meta_cur[MW-1:FB]);
            out_count_reg <= upd_count;
            out_words_reg <= upd_words;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {1'b0, out_words_reg, out_count_reg, out_addr_reg};

    `RPWC_ASSERT(a_stall_no_write, clk, rst_n, (s1_valid_reg && !s1_go) |-> (!meta_we && !line_we), "write-back while stage stalled")
    `RPWC_ASSERT(a_count_range, clk, rst_n, out_valid_reg |-> (out_count_reg != '0 && out_count_reg <= COUNT_W'(LINE_SIZE)), "result byte count out of range")
    `RPWC_ASSERT_NEXT(a_emit_lands, clk, rst_n, (s1_go && ctl.emit), out_valid_reg, "emitted result not held")
    `RPWC_ASSERT_NEXT(a_valid_set, clk, rst_n, meta_we, vld_reg[$past(s1_part_reg)], "entry valid bit not set after write")
endmodule

// File: test/radix_partition_write_combiner_core_tb.sv
// Testbench for the radix partition write combiner: directed table, then random rows.
`timescale 1ns / 1ps
module radix_partition_write_combiner_core_tb import rpwc_pkg::*;;

    typedef struct {
        logic [1:0]   mode;
        logic [31:0]  hash;
        logic [7:0]   tgt;
        logic [47:0]  base;
        logic [63:0]  w [4];
    } req_t;

    typedef struct {
        logic [1:0]   kind;
        logic [47:0]  addr;
        logic [6:0]   cnt;
        logic [63:0]  w [8];
    } wr_t;

    typedef struct {
        req_t req;
        bit   has_exp;
        wr_t  exp;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0] m_tuser;

    radix_partition_write_combiner_core DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid),
        .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor state
    logic [63:0] line_mem [256][8];
    logic [6:0]  fill_mem [256];
    logic [47:0] cursor_mem [256];
    logic [4:0]  shift_r;
    logic [7:0]  mask_r;
    logic [1:0]  wcode_r;

    wr_t pending_writes [$];
    int  errors = 0;
    bit  rx_hold = 1'b0;
    bit  no_idle = 1'b0;
    bit  long_stall = 1'b0;

    function automatic logic [7:0] route_of(logic [31:0] h);
        return 8'((h >> shift_r) & {24'd0, mask_r});
    endfunction

    function automatic void mask_tail(ref logic [63:0] w [8], input int cnt);
        for (int i = 0; i < 8; i++)
        begin
            if (cnt <= 8 * i)
                w[i] = '0;
            else if (cnt < 8 * i + 8)
                w[i] &= (64'd1 << ((cnt - 8 * i) * 8)) - 64'd1;
        end
    endfunction

    // returns 1 when the request produces a write
    function automatic bit predict_write(req_t r, output wr_t o);
        int width;
        int f;
        logic [7:0] p;
        logic [47:0] cur;
        o.kind = '0; o.addr = '0; o.cnt = '0;
        for (int i = 0; i < 8; i++) o.w[i] = '0;
        width = 4 << wcode_r;
        case (r.mode)
            MODE_SEED:
            begin
                cursor_mem[r.tgt] = r.base;
                fill_mem[r.tgt] = '0;
                return 0;
            end
            MODE_DRAIN:
            begin
                f = int'(fill_mem[r.tgt]);
                if (f == 0) return 0;
                o.kind = KIND_RESID;
                o.addr = cursor_mem[r.tgt];
                o.cnt = 7'(f);
                for (int i = 0; i < 8; i++) o.w[i] = line_mem[r.tgt][i];
                mask_tail(o.w, f);
                cursor_mem[r.tgt] = cursor_mem[r.tgt] + 48'(f);
                fill_mem[r.tgt] = '0;
                return 1;
            end
            MODE_ROW:
            begin
                p = route_of(r.hash);
                cur = cursor_mem[p];
                if (cur[5:0] != 0)
                begin
                    o.kind = KIND_PEEL;
                    o.addr = cur;
                    o.cnt = 7'(width);
                    for (int i = 0; i < 4; i++) o.w[i] = r.w[i];
                    mask_tail(o.w, width);
                    cursor_mem[p] = cur + 48'(width);
                    return 1;
                end
                f = int'(fill_mem[p]);
                for (int k = 0; k < width && f + k < 64; k++)
                    line_mem[p][(f + k) >> 3][((f + k) & 7) * 8 +: 8] =
                        r.w[k >> 3][(k & 7) * 8 +: 8];
                f += width;
                if (f >= 64)
                begin
                    o.kind = KIND_LINE;
                    o.addr = cur;
                    o.cnt = 7'd64;
                    for (int i = 0; i < 8; i++) o.w[i] = line_mem[p][i];
                    cursor_mem[p] = cur + 48'd64;
                    fill_mem[p] = '0;
                    return 1;
                end
                fill_mem[p] = 7'(f);
                return 0;
            end
            default: return 0;
        endcase
    endfunction

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [7:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SHIFT: shift_r = val[4:0];
            CFG_MASK:  mask_r = val;
            default:   wcode_r = val[1:0];
        endcase
        @(posedge clk);
    endtask

    task automatic send_req(req_t r);
        wr_t o;
        if (!no_idle && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= r.mode;
        s_tdata <= {r.w[3], r.w[2], r.w[1], r.w[0], r.base, r.tgt, r.hash};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (predict_write(r, o)) pending_writes.push_back(o);
    endtask

    // sink side: checks each result in order; random back-pressure plus the long hold-off
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            wr_t e;
            wr_t got;
            bit bad;
            got.kind = m_tuser;
            {got.w[7], got.w[6], got.w[5], got.w[4], got.w[3], got.w[2], got.w[1],
             got.w[0], got.cnt, got.addr} = m_tdata[OUT_DATA_W-2:0];
            if (pending_writes.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected write addr=%h", got.addr);
            end
            else
            begin
                e = pending_writes.pop_front();
                bad = (e.kind !== got.kind) || (e.addr !== got.addr) || (e.cnt !== got.cnt);
                for (int i = 0; i < 8; i++) if (e.w[i] !== got.w[i]) bad = 1'b1;
                if (m_tdata[OUT_DATA_W-1] !== 1'b0) bad = 1'b1;
                if (bad)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp k=%0d a=%h n=%0d w0=%h got k=%0d a=%h n=%0d w0=%h",
                            e.kind, e.addr, e.cnt, e.w[0], got.kind, got.addr, got.cnt,
                            got.w[0]);
                end
            end
        end
        if (long_stall)
            m_tready <= 1'b0;
        else if (no_idle)
            m_tready <= 1'b1;
        else if (rx_hold)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 4) != 0);
    end

    // idle bursts on the sink
    initial
    begin
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 20) == 0)
            begin
                rx_hold = 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                rx_hold = 1'b0;
            end
        end
    end

    function automatic req_t mk_req(logic [1:0] m, logic [31:0] h, logic [7:0] t,
                                    logic [47:0] b, logic [63:0] d);
        req_t r;
        r.mode = m; r.hash = h; r.tgt = t; r.base = b;
        for (int i = 0; i < 4; i++) r.w[i] = d ^ {8{i[7:0]}};
        return r;
    endfunction

    function automatic req_t rand_req(int lanes);
        req_t r;
        int pick;
        pick = $urandom_range(0, 99);
        r.hash = $urandom();
        r.tgt = 8'($urandom_range(0, lanes - 1));
        r.base = 48'({$urandom(), $urandom()});
        if ($urandom_range(0, 2) != 0) r.base[5:0] = '0;
        for (int i = 0; i < 4; i++) r.w[i] = {$urandom(), $urandom()};
        if (pick < 80) r.mode = MODE_ROW;
        else if (pick < 88) r.mode = MODE_DRAIN;
        else if (pick < 97) r.mode = MODE_SEED;
        else r.mode = 2'd3;
        return r;
    endfunction

    // reseed every partition the current routing can reach
    task automatic seed_all();
        for (int p = 0; p < 256; p++)
            if ((p & ~int'(mask_r)) == 0)
                send_req(mk_req(MODE_SEED, '0, 8'(p),
                                48'({$urandom(), $urandom()}) & ~48'h3F, '0));
    endtask

    row_t dir_rows [$];

    initial
    begin
        row_t d;
        req_t r;
        logic [7:0] mask_set [4];
        shift_r = '0; mask_r = 8'd255; wcode_r = 2'd1;
        for (int p = 0; p < 256; p++)
        begin
            fill_mem[p] = '0; cursor_mem[p] = '0;
            for (int i = 0; i < 8; i++) line_mem[p][i] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; expectations given only for the obvious rows
        d.has_exp = 0;
        d.req = mk_req(MODE_SEED, '0, 8'd0, 48'h0, '0); dir_rows.push_back(d);
        d.req = mk_req(MODE_SEED, '0, 8'd255, 48'hFFFF_FFFF_FFFC, '0); dir_rows.push_back(d);
        d.req = mk_req(MODE_SEED, '0, 8'd7, 48'h1000, '0); dir_rows.push_back(d);
        // empty drain: nothing
        d.req = mk_req(MODE_DRAIN, '0, 8'd0, '0, '0); dir_rows.push_back(d);
        // unknown mode ignored
        d.req = mk_req(2'd3, 32'hFFFF_FFFF, 8'hFF, 48'hFFFF_FFFF_FFFF, '1);
        dir_rows.push_back(d);
        // head peel at top address, cursor wraps
        d.has_exp = 1;
        d.exp.kind = KIND_PEEL; d.exp.addr = 48'hFFFF_FFFF_FFFC; d.exp.cnt = 7'd8;
        for (int i = 0; i < 8; i++) d.exp.w[i] = '0;
        d.exp.w[0] = 64'hFFFF_FFFF_FFFF_FFFF;
        d.req = mk_req(MODE_ROW, 32'hFFFF_FFFF, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF);
        dir_rows.push_back(d);
        d.has_exp = 0;
        d.req = mk_req(MODE_ROW, 32'h0000_00FF, '0, '0, '0); dir_rows.push_back(d);
        for (int k = 0; k < 8; k++)
        begin
            d.req = mk_req(MODE_ROW, 32'h0000_0007, '0, '0, {8{k[7:0]}});
            dir_rows.push_back(d);
        end
        for (int k = 0; k < 3; k++)
        begin
            d.req = mk_req(MODE_ROW, 32'h0000_0100, '0, '0, 64'hA5A5_0000_0000_5A5A + k);
            dir_rows.push_back(d);
        end
        d.req = mk_req(MODE_DRAIN, '0, 8'd0, '0, '0); dir_rows.push_back(d);
        d.req = mk_req(MODE_DRAIN, '0, 8'd255, '0, '0); dir_rows.push_back(d);

        foreach (dir_rows[i])
        begin
            r = dir_rows[i].req;
            send_req(r);
            if (dir_rows[i].has_exp && pending_writes.size() != 0)
                pending_writes[$] = dir_rows[i].exp;
        end
        wait_idle();

        // line overrun: small elements leave a partial fill, then the width grows
        write_reg(CFG_WIDTH, 8'd0);
        write_reg(CFG_SHIFT, 8'd31);
        write_reg(CFG_MASK, 8'd1);
        seed_all();
        for (int i = 0; i < 20; i++) send_req(rand_req(2));
        wait_idle();
        write_reg(CFG_WIDTH, 8'd3);
        for (int i = 0; i < 4; i++) send_req(rand_req(2));
        wait_idle();

        mask_set[0] = 8'd255; mask_set[1] = 8'd0; mask_set[2] = 8'd15; mask_set[3] = 8'd3;
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(CFG_SHIFT, ph == 0 ? 8'd0 : 8'($urandom_range(0, 31)));
            write_reg(CFG_MASK, mask_set[ph % 4]);
            write_reg(CFG_WIDTH, 8'(ph % 4));
            seed_all();
            if (ph == 7) no_idle = 1'b1;
            for (int i = 0; i < 110; i++)
            begin
                r = rand_req(int'(mask_r) + 1);
                if (r.mode == MODE_SEED && $urandom_range(0, 1) == 0) r.base[5:0] = '0;
                send_req(r);
            end
            // sender pause: let everything drain
            if (ph == 2) wait_idle();
            if (ph == 4)
            begin
                fork
                    begin
                        long_stall = 1'b1;
                        repeat (300) @(posedge clk);
                        long_stall = 1'b0;
                    end
                    begin
                        for (int i = 0; i < 60; i++)
                        begin
                            r = rand_req(int'(mask_r) + 1);
                            r.mode = MODE_ROW;
                            send_req(r);
                        end
                    end
                join
            end
            wait_idle();
        end

        for (int i = 0; i < 1000 && pending_writes.size() != 0; i++) @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0 && pending_writes.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("simulation failed");
        $finish;
    end
endmodule
